// ===== design/fps_pkg.sv =====
// Shared constants, types and state codes for the farthest point sampler.
package fps_pkg;

  localparam int MaxPoints  = 1024;
  localparam int MaxDims    = 8;
  localparam int MaxPicks   = 64;
  localparam int CoordW     = 16;
  localparam int StoreDepth = MaxPoints * MaxDims;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int PointAw    = $clog2(MaxPoints);
  localparam int PointCntW  = PointAw + 1;
  localparam int BaseW      = StoreAw + 1;
  localparam int TotalW     = 15;
  localparam int DimW       = 4;
  localparam int PickW      = 7;
  localparam int SumW       = 26;
  localparam int DistW      = 37;
  localparam int MulW       = 28;
  localparam int ProdW      = 2 * MulW;
  localparam int MetricW    = 56;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 11;

  localparam logic [DistW-1:0] DistInf = {DistW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_POINTS = 2'd0,
    CFG_NUM_DIMS   = 2'd1,
    CFG_NUM_PICKS  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef enum logic [12:0] {
    S_LOAD    = 13'b0000000000001,
    S_SUM_RD  = 13'b0000000000010,
    S_SUM_ACC = 13'b0000000000100,
    S_C_RD    = 13'b0000000001000,
    S_C_M1    = 13'b0000000010000,
    S_C_M2    = 13'b0000000100000,
    S_C_AC    = 13'b0000001000000,
    S_C_CMP   = 13'b0000010000000,
    S_EMIT    = 13'b0000100000000,
    S_P_RD    = 13'b0001000000000,
    S_P_M     = 13'b0010000000000,
    S_P_AC    = 13'b0100000000000,
    S_P_UPD   = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic             chosen;
    logic [DistW-1:0] min_d;
  } near_t;

endpackage

// ===== design/fps_ram.sv =====
// Simple one-write one-read memory with registered read data.
module fps_ram #(
  parameter int Depth = 1024,
  parameter int Width = 16,
  parameter int Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fps_mul.sv =====
// Shared signed multiplier with a registered product.
module fps_mul import fps_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== design/farthest_point_sampling.sv =====
// Top level of the farthest point sampler: load, sequencer and output register.
//
// Coordinates enter on the s_axis channel, one signed Q8.8 value per beat, in
// row-major order. Configuration is written through cfg_we_i / cfg_addr_i /
// cfg_data_i while the block is idle: 0 num_points, 1 num_dims, 2 num_picks.
// Load beats are taken one per cycle. The beat that completes the cloud starts
// the selection and s_axis_tready drops until the last pick has been handed to
// the output register. Selection runs on one shared multiplier: summing reads and
// adds each coordinate, the centroid pass reads, multiplies twice and adds each
// coordinate and compares each point, each later pick reads, multiplies and adds
// each coordinate and updates each point, then emits. Picks leave on m_axis with
// tlast on the final one; tuser is 1 on the single error beat a bad configuration
// gives for each input beat. A stalled receiver holds the sequencer at its emit
// step and, with a bad configuration, holds off input. Reset returns to loading
// with registers at 1, no points loaded and the output empty.
module farthest_point_sampling import fps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] coord
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [9:0] pick_index, [15:10] zero
  output logic                m_axis_tlast,   // last_pick
  output logic                m_axis_tuser    // status
);

  state_e st_q, st_d;

  logic [10:0]         npts_q;
  logic [DimW-1:0]     ndims_q;
  logic [PickW-1:0]    npicks_q;
  logic [BaseW-1:0]    load_q;
  logic [BaseW-1:0]    base_q;
  logic [BaseW-1:0]    bbase_q;
  logic [BaseW-1:0]    pbase_q;
  logic [PointCntW-1:0] i_q;
  logic [PointAw-1:0]  bi_q;
  logic [PointAw-1:0]  pi_q;
  logic [DimW-1:0]     j_q;
  logic [PickW-1:0]    cnt_q;
  logic [MetricW-1:0]  acc_q;
  logic [MetricW-1:0]  best_q;
  logic                found_q;
  logic signed [SumW-1:0] sums_q [MaxDims];

  logic                m_valid_q;
  logic [PointAw-1:0]  m_idx_q;
  logic                m_last_q;
  logic                m_err_q;

  logic                cfg_ok;
  logic [TotalW-1:0]   total;
  logic                out_free;
  logic                out_load;
  logic                in_fire;
  logic                j_last;
  logic                i_last;
  logic [BaseW-1:0]    addr_a;
  logic [BaseW-1:0]    addr_b;
  logic [CoordW-1:0]   rd_a;
  logic [CoordW-1:0]   rd_b;
  near_t               near_rd;
  near_t               near_wr;
  logic                near_we;
  logic signed [MulW-1:0]  mul_a;
  logic signed [MulW-1:0]  mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [MulW-1:0]  cen_diff;
  logic signed [MulW-1:0]  pt_diff;
  logic [DistW-1:0]    new_dist;
  logic [DistW-1:0]    dist_sq;
  logic                is_pick;

  assign total = TotalW'(npts_q) * TotalW'(ndims_q);
  assign cfg_ok = (npts_q >= 11'd1) && (npts_q <= 11'(MaxPoints)) &&
                  (ndims_q >= 4'd1) && (ndims_q <= 4'(MaxDims)) &&
                  (npicks_q >= 7'd1) && (npicks_q <= 7'(MaxPicks)) &&
                  (11'(npicks_q) <= npts_q);
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (st_q == S_LOAD) && (cfg_ok || out_free);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_load = ((st_q == S_LOAD) && in_fire && !cfg_ok) ||
                    ((st_q == S_EMIT) && out_free);
  assign j_last = (j_q == ndims_q - 4'd1);
  assign i_last = (i_q == PointCntW'(npts_q - 11'd1));

  assign addr_a = (st_q == S_SUM_RD) ? base_q : base_q + BaseW'(j_q);
  assign addr_b = pbase_q + BaseW'(j_q);

  fps_ram #(.Depth(StoreDepth), .Width(CoordW)) u_pts_a (
    .clk_i  (clk_i),
    .we_i   (in_fire && cfg_ok && (TotalW'(load_q) < total)),
    .waddr_i(load_q[StoreAw-1:0]),
    .wdata_i(s_axis_tdata),
    .re_i   (1'b1),
    .raddr_i(addr_a[StoreAw-1:0]),
    .rdata_o(rd_a)
  );

  fps_ram #(.Depth(StoreDepth), .Width(CoordW)) u_pts_b (
    .clk_i  (clk_i),
    .we_i   (in_fire && cfg_ok && (TotalW'(load_q) < total)),
    .waddr_i(load_q[StoreAw-1:0]),
    .wdata_i(s_axis_tdata),
    .re_i   (1'b1),
    .raddr_i(addr_b[StoreAw-1:0]),
    .rdata_o(rd_b)
  );

  fps_ram #(.Depth(MaxPoints), .Width(DistW + 1)) u_near (
    .clk_i  (clk_i),
    .we_i   (near_we),
    .waddr_i(i_q[PointAw-1:0]),
    .wdata_i(near_wr),
    .re_i   (st_q == S_P_RD),
    .raddr_i(i_q[PointAw-1:0]),
    .rdata_o(near_rd)
  );

  // n*x - S_j for the centroid metric, x_i - x_pick for distances
  assign cen_diff = MulW'(signed'(prod[MulW-2:0])) - MulW'(sums_q[j_q[2:0]]);
  assign pt_diff  = MulW'(signed'(rd_a)) - MulW'(signed'(rd_b));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      S_C_M1: begin
        mul_a = MulW'(signed'({1'b0, npts_q}));
        mul_b = MulW'(signed'(rd_a));
      end
      S_C_M2: begin
        mul_a = cen_diff;
        mul_b = cen_diff;
      end
      S_P_M: begin
        mul_a = pt_diff;
        mul_b = pt_diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fps_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  assign dist_sq  = acc_q[DistW-1:0];
  assign is_pick  = (i_q[PointAw-1:0] == pi_q);
  assign new_dist = (dist_sq < near_rd.min_d) ? dist_sq : near_rd.min_d;

  always_comb begin
    near_we = 1'b0;
    near_wr = '{chosen: 1'b0, min_d: DistInf};
    if (st_q == S_C_CMP) begin
      near_we = 1'b1;
    end else if (st_q == S_P_UPD && !near_rd.chosen) begin
      near_we = 1'b1;
      near_wr = '{chosen: is_pick, min_d: new_dist};
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_LOAD: begin
        if (in_fire && cfg_ok &&
            ((TotalW'(load_q) >= total) || (TotalW'(load_q) + 15'd1 >= total))) begin
          st_d = S_SUM_RD;
        end
      end
      S_SUM_RD:  st_d = S_SUM_ACC;
      S_SUM_ACC: st_d = (TotalW'(base_q) == total - 15'd1) ? S_C_RD : S_SUM_RD;
      S_C_RD:    st_d = S_C_M1;
      S_C_M1:    st_d = S_C_M2;
      S_C_M2:    st_d = S_C_AC;
      S_C_AC:    st_d = j_last ? S_C_CMP : S_C_RD;
      S_C_CMP:   st_d = i_last ? S_EMIT : S_C_RD;
      S_EMIT: begin
        if (out_free) begin
          st_d = (cnt_q + 7'd1 == npicks_q) ? S_LOAD : S_P_RD;
        end
      end
      S_P_RD:    st_d = S_P_M;
      S_P_M:     st_d = S_P_AC;
      S_P_AC:    st_d = j_last ? S_P_UPD : S_P_RD;
      S_P_UPD:   st_d = i_last ? S_EMIT : S_P_RD;
      default:   st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_LOAD;
      npts_q    <= 11'd1;
      ndims_q   <= 4'd1;
      npicks_q  <= 7'd1;
      load_q    <= '0;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      for (int k = 0; k < MaxDims; k++) begin
        sums_q[k] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_NUM_POINTS: npts_q   <= cfg_data_i;
          CFG_NUM_DIMS:   ndims_q  <= cfg_data_i[DimW-1:0];
          CFG_NUM_PICKS:  npicks_q <= cfg_data_i[PickW-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (st_q)
        S_LOAD: begin
          if (in_fire) begin
            if (!cfg_ok) begin
              // drop the beat, report the bad configuration
              load_q    <= '0;
              m_idx_q   <= '0;
              m_last_q  <= 1'b1;
              m_err_q   <= 1'b1;
            end else begin
              if (TotalW'(load_q) < total) begin
                load_q <= load_q + BaseW'(1);
              end
              base_q <= '0;
              j_q    <= '0;
              for (int k = 0; k < MaxDims; k++) begin
                sums_q[k] <= '0;
              end
            end
          end
        end
        S_SUM_ACC: begin
          sums_q[j_q[2:0]] <= sums_q[j_q[2:0]] + SumW'(signed'(rd_a));
          j_q <= j_last ? '0 : j_q + 4'd1;
          if (TotalW'(base_q) == total - 15'd1) begin
            base_q  <= '0;
            i_q     <= '0;
            acc_q   <= '0;
            found_q <= 1'b0;
          end else begin
            base_q <= base_q + BaseW'(1);
          end
        end
        S_C_AC, S_P_AC: begin
          acc_q <= acc_q + MetricW'(unsigned'(prod));
          if (!j_last) begin
            j_q <= j_q + 4'd1;
          end
        end
        S_C_CMP: begin
          if (!found_q || acc_q > best_q) begin
            found_q <= 1'b1;
            best_q  <= acc_q;
            bi_q    <= i_q[PointAw-1:0];
            bbase_q <= base_q;
          end
          i_q    <= i_q + PointCntW'(1);
          base_q <= base_q + BaseW'(ndims_q);
          j_q    <= '0;
          acc_q  <= '0;
        end
        S_EMIT: begin
          if (out_free) begin
            m_idx_q   <= bi_q;
            m_last_q  <= (cnt_q + 7'd1 == npicks_q);
            m_err_q   <= 1'b0;
            pi_q      <= bi_q;
            pbase_q   <= bbase_q;
            i_q       <= '0;
            base_q    <= '0;
            j_q       <= '0;
            acc_q     <= '0;
            best_q    <= '0;
            found_q   <= 1'b0;
            if (cnt_q + 7'd1 == npicks_q) begin
              cnt_q  <= '0;
              load_q <= '0;
            end else begin
              cnt_q <= cnt_q + 7'd1;
            end
          end
        end
        S_P_UPD: begin
          if (!near_rd.chosen && !is_pick &&
              (!found_q || MetricW'(new_dist) > best_q)) begin
            found_q <= 1'b1;
            best_q  <= MetricW'(new_dist);
            bi_q    <= i_q[PointAw-1:0];
            bbase_q <= base_q;
          end
          i_q    <= i_q + PointCntW'(1);
          base_q <= base_q + BaseW'(ndims_q);
          j_q    <= '0;
          acc_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(16 - PointAw){1'b0}}, m_idx_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_err_q;

  a_ready_only_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> st_q == S_LOAD)
    else $error("input ready outside the load phase");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_err_q) |-> m_last_q)
    else $error("error beat without tlast");

  a_emit_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EMIT && out_free) |=> m_valid_q)
    else $error("pick lost at emit");

endmodule
